[design/dtpw_pkg.sv]
// Package for the prescaled dual timer with watchdog.
// Item kinds, register map, control bits and the packed result word.
// No dependencies.
package dtpw_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  localparam logic [INDEX_W-1:0] REG_COUNT1   = 4'd0;
  localparam logic [INDEX_W-1:0] REG_RELOAD1  = 4'd1;
  localparam logic [INDEX_W-1:0] REG_CTRL1    = 4'd2;
  localparam logic [INDEX_W-1:0] REG_WATCHDOG = 4'd3;
  localparam logic [INDEX_W-1:0] REG_COUNT2   = 4'd4;
  localparam logic [INDEX_W-1:0] REG_RELOAD2  = 4'd5;
  localparam logic [INDEX_W-1:0] REG_CTRL2    = 4'd6;
  localparam logic [INDEX_W-1:0] REG_PRE_CNT  = 4'd7;
  localparam logic [INDEX_W-1:0] REG_PRE_RLD  = 4'd8;

  localparam int unsigned CTRL_EN_BIT = 0;
  localparam int unsigned CTRL_RL_BIT = 1;
  localparam int unsigned CTRL_LD_BIT = 2;

  typedef struct packed {
    logic              watchdog_expired;
    logic              timer2_irq;
    logic              timer1_irq;
    logic              access_error;
    logic [WORD_W-1:0] read_data;
  } result_t;

endpackage

[design/dual_timer_prescaler_watchdog_unit.sv]
// Top level of the prescaled dual timer with watchdog.
// Register file, prescaler, timers, watchdog and a two-entry output buffer.
// Depends on dtpw_pkg.
//
// Usage:
//   The in_ channel carries one item per handshake: a register read, a
//   register write or a clock tick (in_tuser). in_tdata holds the register
//   index and the write word. The out_ channel returns exactly one result
//   item per input item, in order: read data, access error and the three
//   tick flags.
//   Each result is registered in the output buffer. Throughput is one
//   item per cycle while in_tready is high; the register file, prescaler,
//   timers and watchdog all update in the cycle an item is accepted.
//   When the receiver stalls, one more result is parked in a skid register
//   and in_tready drops until the receiver takes the waiting result, so no
//   result is lost.
//   Reset (rst_n low, synchronous) clears the timer and prescaler counters,
//   reload and control registers to zero, sets the watchdog counter to all
//   ones and empties the output buffer.
module dual_timer_prescaler_watchdog_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dtpw_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] reg_index, [35:4] write_data,
                                                        // [39:36] zero
  input  logic [dtpw_pkg::KIND_W-1:0]       in_tuser,   // [1:0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dtpw_pkg::OUT_TDATA_W-1:0]  out_tdata   // [31:0] read_data, [32] access_error,
                                                        // [33] timer1_irq, [34] timer2_irq,
                                                        // [35] watchdog_expired, [39:36] zero
);

  localparam int unsigned W = dtpw_pkg::WORD_W;

  logic [W-1:0] t1_count_r, t1_count_nxt;
  logic [W-1:0] t1_reload_r, t1_reload_nxt;
  logic [W-1:0] t1_ctrl_r, t1_ctrl_nxt;
  logic [W-1:0] t2_count_r, t2_count_nxt;
  logic [W-1:0] t2_reload_r, t2_reload_nxt;
  logic [W-1:0] t2_ctrl_r, t2_ctrl_nxt;
  logic [W-1:0] wd_count_r, wd_count_nxt;
  logic [W-1:0] pre_count_r, pre_count_nxt;
  logic [W-1:0] pre_reload_r, pre_reload_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  dtpw_pkg::result_t    out_data_r, out_data_nxt;
  dtpw_pkg::result_t    skid_data_r, skid_data_nxt;
  dtpw_pkg::result_t    res;

  logic                            acc;
  dtpw_pkg::kind_t                 kind;
  logic [dtpw_pkg::INDEX_W-1:0]    idx;
  logic [W-1:0]                    wdata;
  logic [W-1:0]                    wdata_ctl;
  logic [W-1:0]                    pre_dec, t1_dec, t2_dec, wd_dec;
  logic                            pre_fire;

  assign kind  = dtpw_pkg::kind_t'(in_tuser);
  assign idx   = in_tdata[dtpw_pkg::INDEX_W-1:0];
  assign wdata = in_tdata[dtpw_pkg::INDEX_W +: W];
  assign wdata_ctl = wdata & ~(W'(1) << dtpw_pkg::CTRL_LD_BIT);

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;

  assign pre_dec  = pre_count_r - W'(1);
  assign t1_dec   = t1_count_r - W'(1);
  assign t2_dec   = t2_count_r - W'(1);
  assign wd_dec   = wd_count_r - W'(1);
  assign pre_fire = (pre_dec == '0);

  always_comb begin
    t1_count_nxt   = t1_count_r;
    t1_reload_nxt  = t1_reload_r;
    t1_ctrl_nxt    = t1_ctrl_r;
    t2_count_nxt   = t2_count_r;
    t2_reload_nxt  = t2_reload_r;
    t2_ctrl_nxt    = t2_ctrl_r;
    wd_count_nxt   = wd_count_r;
    pre_count_nxt  = pre_count_r;
    pre_reload_nxt = pre_reload_r;
    res            = '0;

    case (kind)
      dtpw_pkg::KIND_READ: begin
        case (idx)
          dtpw_pkg::REG_COUNT1:   res.read_data = t1_count_r;
          dtpw_pkg::REG_RELOAD1:  res.read_data = t1_reload_r;
          dtpw_pkg::REG_CTRL1:    res.read_data = t1_ctrl_r;
          dtpw_pkg::REG_WATCHDOG: res.read_data = wd_count_r;
          dtpw_pkg::REG_COUNT2:   res.read_data = t2_count_r;
          dtpw_pkg::REG_RELOAD2:  res.read_data = t2_reload_r;
          dtpw_pkg::REG_CTRL2:    res.read_data = t2_ctrl_r;
          dtpw_pkg::REG_PRE_CNT:  res.read_data = pre_count_r;
          dtpw_pkg::REG_PRE_RLD:  res.read_data = pre_reload_r;
          default:                res.access_error = 1'b1;
        endcase
      end
      dtpw_pkg::KIND_WRITE: begin
        case (idx)
          dtpw_pkg::REG_COUNT1:   t1_count_nxt = wdata;
          dtpw_pkg::REG_RELOAD1:  t1_reload_nxt = wdata;
          dtpw_pkg::REG_CTRL1: begin
            t1_ctrl_nxt = wdata_ctl;
            if (wdata[dtpw_pkg::CTRL_LD_BIT]) t1_count_nxt = t1_reload_r;
          end
          dtpw_pkg::REG_WATCHDOG: wd_count_nxt = wdata;
          dtpw_pkg::REG_COUNT2:   t2_count_nxt = wdata;
          dtpw_pkg::REG_RELOAD2:  t2_reload_nxt = wdata;
          dtpw_pkg::REG_CTRL2: begin
            t2_ctrl_nxt = wdata_ctl;
            if (wdata[dtpw_pkg::CTRL_LD_BIT]) t2_count_nxt = t2_reload_r;
          end
          dtpw_pkg::REG_PRE_CNT:  pre_count_nxt = wdata;
          dtpw_pkg::REG_PRE_RLD:  pre_reload_nxt = wdata;
          default:                res.access_error = 1'b1;
        endcase
      end
      dtpw_pkg::KIND_TICK: begin
        pre_count_nxt = pre_dec;
        if (pre_fire) begin
          pre_count_nxt = pre_reload_r;
          if (t1_ctrl_r[dtpw_pkg::CTRL_EN_BIT]) begin
            t1_count_nxt = t1_dec;
            if (t1_dec == '0) begin
              res.timer1_irq = 1'b1;
              if (t1_ctrl_r[dtpw_pkg::CTRL_RL_BIT]) t1_count_nxt = t1_reload_r;
            end
          end
          if (t2_ctrl_r[dtpw_pkg::CTRL_EN_BIT]) begin
            t2_count_nxt = t2_dec;
            if (t2_dec == '0) begin
              res.timer2_irq = 1'b1;
              if (t2_ctrl_r[dtpw_pkg::CTRL_RL_BIT]) t2_count_nxt = t2_reload_r;
            end
          end
          wd_count_nxt = wd_dec;
          if (wd_dec == '0) begin
            res.watchdog_expired = 1'b1;
            wd_count_nxt = dtpw_pkg::ALL_ONES;
          end
        end
      end
      default: ;
    endcase
  end

  // output buffer: main register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (acc) begin
        out_data_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (out_valid_r) begin
      if (acc) begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (acc) begin
      out_data_nxt  = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_count_r   <= '0;
      t1_reload_r  <= '0;
      t1_ctrl_r    <= '0;
      t2_count_r   <= '0;
      t2_reload_r  <= '0;
      t2_ctrl_r    <= '0;
      wd_count_r   <= dtpw_pkg::ALL_ONES;
      pre_count_r  <= '0;
      pre_reload_r <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        t1_count_r   <= t1_count_nxt;
        t1_reload_r  <= t1_reload_nxt;
        t1_ctrl_r    <= t1_ctrl_nxt;
        t2_count_r   <= t2_count_nxt;
        t2_reload_r  <= t2_reload_nxt;
        t2_ctrl_r    <= t2_ctrl_nxt;
        wd_count_r   <= wd_count_nxt;
        pre_count_r  <= pre_count_nxt;
        pre_reload_r <= pre_reload_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_err_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.access_error |->
      !out_data_r.timer1_irq && !out_data_r.timer2_irq && !out_data_r.watchdog_expired)
    else $error("access error reported together with tick flags");

  a_tick_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.timer1_irq || out_data_r.timer2_irq ||
                    out_data_r.watchdog_expired) |-> out_data_r.read_data == '0)
    else $error("tick result carries read data");

  a_pre_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind != dtpw_pkg::KIND_TICK &&
    !(kind == dtpw_pkg::KIND_WRITE && idx == dtpw_pkg::REG_PRE_CNT)
    |=> pre_count_r == $past(pre_count_r))
    else $error("prescaler moved without a tick or write");

  a_wd_nonzero_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == dtpw_pkg::KIND_TICK && wd_count_r != '0 |=> wd_count_r != '0)
    else $error("watchdog counter left at zero after a tick");

endmodule
